[rtl/core/lru_sc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lru_sc_pkg;
	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_W     = 4;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// operation codes
	localparam logic [2:0] OP_ADD      = 3'd0;
	localparam logic [2:0] OP_LOOK_KEY = 3'd1;
	localparam logic [2:0] OP_LOOK_DSC = 3'd2;
	localparam logic [2:0] OP_CHK_DSC  = 3'd3;
	localparam logic [2:0] OP_DEL_KEY  = 3'd4;
	localparam logic [2:0] OP_EXPIRE   = 3'd5;

	// timer action codes
	localparam logic [1:0] TMR_NONE    = 2'd0;
	localparam logic [1:0] TMR_START   = 2'd1;
	localparam logic [1:0] TMR_RESTART = 2'd2;

	// stored slot contents
	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [31:0]         desc;
		logic [31:0]         auth;
		logic [15:0]         ver;
		logic [7:0]          hash;
		logic [7:0]          sign;
	} slot_data_t;
endpackage
`default_nettype wire

[rtl/core/lru_session_cache.sv]
// LRU session cache.
// Input channel (in_valid / in_stall) takes one operation word: opcode, key,
// descriptor, attribute fields and the expiry slot. Output channel
// (out_valid / out_stall) returns exactly one result word per operation:
// status, slot, timer action and, for add, lookup and check hits, the stored fields of the hit slot.
// Slot state lives in two synchronous memories (counters, slot data) with
// registered read outputs, plus a valid bit per slot held in flops.
// Each operation but expire sweeps all slots, reading one slot per cycle
// (add also writes back each decremented counter), then finishes once the
// output register is free; expire goes straight to the finish step. The
// next word is accepted in the cycle after the finish. The slot sweep sets
// the rate; one operation is swept at a time.
// in_stall is high while an operation is in progress. The result sits in an
// output register; while out_stall holds it, the next operation may still be
// accepted and swept, and its finish waits for the register to free up.
// Reset (arst_n low) clears all valid bits, so every slot reads as free with
// a zero counter; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module lru_session_cache (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [63:0] session_key,
	input  wire logic [31:0] descriptor,
	input  wire logic [31:0] auth_ident,
	input  wire logic [15:0] proto_version,
	input  wire logic [7:0]  hash_alg,
	input  wire logic [7:0]  sign_alg,
	input  wire logic [3:0]  expire_slot,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [3:0]       slot,
	output logic [1:0]       timer_action,
	output logic [63:0]      found_key,
	output logic [31:0]      found_descriptor,
	output logic [31:0]      found_auth,
	output logic [15:0]      found_version,
	output logic [7:0]       found_hash,
	output logic [7:0]       found_sign
);
	localparam int IB = lru_sc_pkg::IDX_BITS;
	localparam int CB = lru_sc_pkg::COUNT_BITS;
	localparam int KB = lru_sc_pkg::KEY_BITS;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;
	state_t state_q;

	// memories
	logic [CB-1:0]          age_mem [lru_sc_pkg::ENTRIES];
	lru_sc_pkg::slot_data_t data_mem [lru_sc_pkg::ENTRIES];
	logic [lru_sc_pkg::ENTRIES-1:0] valid_q;

	// latched operation
	logic [2:0]             op_q;
	lru_sc_pkg::slot_data_t in_q;
	logic [3:0]             exp_q;

	// sweep control
	logic [IB:0]   rd_cnt_q;
	logic          rd_en;
	logic [IB-1:0] rd_addr;
	logic          p_valid_s1;
	logic [IB-1:0] p_idx_s1;
	logic          v_s1;
	logic [CB-1:0] age_s1;
	lru_sc_pkg::slot_data_t data_s1;

	// sweep results
	logic          found_q;
	logic [IB-1:0] fidx_q;
	lru_sc_pkg::slot_data_t cap_q;
	logic [CB-1:0] least_q;
	logic [IB-1:0] victim_q;

	// write ports
	logic          age_we;
	logic [IB-1:0] age_wa;
	logic [CB-1:0] age_wd;
	logic          data_we;

	// per-slot evaluation
	logic [CB-1:0] age_v, age_dec;
	logic          live, key_hit, dsc_hit, match;

	// finish result
	logic          res_status;
	logic [3:0]    res_slot;
	logic [1:0]    res_tmr;
	logic          res_show;

	// slot index to output width
	function automatic logic [lru_sc_pkg::SLOT_W-1:0] SLOT_W_CAST(input logic [IB-1:0] idx);
		logic [IB+lru_sc_pkg::SLOT_W-1:0] wide;
		wide = (IB+lru_sc_pkg::SLOT_W)'(idx);
		return wide[lru_sc_pkg::SLOT_W-1:0];
	endfunction

	assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q < (IB+1)'(lru_sc_pkg::ENTRIES));
	assign rd_addr = rd_cnt_q[IB-1:0];

	always_comb begin
		age_v   = v_s1 ? age_s1 : '0;
		live    = (age_v != '0);
		age_dec = live ? (age_v - CB'(1)) : age_v;
		key_hit = (data_s1.key == in_q.key);
		dsc_hit = (data_s1.desc == in_q.desc);
		match   = ((op_q == lru_sc_pkg::OP_LOOK_KEY) || (op_q == lru_sc_pkg::OP_DEL_KEY))
			? key_hit : dsc_hit;
	end

	logic fin_go;
	assign fin_go = (state_q == ST_FIN) && (!out_valid || !out_stall);

	// write port selection: decrement during an add sweep, final update at finish
	always_comb begin
		age_we  = 1'b0;
		age_wa  = p_idx_s1;
		age_wd  = age_dec;
		data_we = 1'b0;
		if (p_valid_s1 && op_q == lru_sc_pkg::OP_ADD && live) begin
			age_we = 1'b1;
		end
		if (fin_go) begin
			age_wd = lru_sc_pkg::COUNT_MAX;
			case (op_q)
				lru_sc_pkg::OP_ADD: begin
					age_we  = 1'b1;
					age_wa  = found_q ? fidx_q : victim_q;
					data_we = !found_q;
				end
				lru_sc_pkg::OP_LOOK_KEY, lru_sc_pkg::OP_LOOK_DSC: begin
					age_we = found_q;
					age_wa = fidx_q;
				end
				default: begin
					age_we = 1'b0;
				end
			endcase
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			age_s1  <= age_mem[rd_addr];
			data_s1 <= data_mem[rd_addr];
		end
		if (age_we) begin
			age_mem[age_wa] <= age_wd;
		end
		if (data_we) begin
			data_mem[victim_q] <= in_q;
		end
	end

	// operation latch, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q        <= opcode;
			in_q.key    <= session_key[KB-1:0];
			in_q.desc   <= descriptor;
			in_q.auth   <= auth_ident;
			in_q.ver    <= proto_version;
			in_q.hash   <= hash_alg;
			in_q.sign   <= sign_alg;
			exp_q       <= expire_slot;
		end
	end

	logic exp_ok;
	assign exp_ok = ({1'b0, exp_q} < 5'(lru_sc_pkg::ENTRIES)) || (lru_sc_pkg::ENTRIES > 16);

	// result word of the finish step
	always_comb begin
		res_status = 1'b0;
		res_slot   = '0;
		res_tmr    = lru_sc_pkg::TMR_NONE;
		res_show   = 1'b0;
		case (op_q)
			lru_sc_pkg::OP_ADD: begin
				if (found_q) begin
					res_status = 1'b1;
					res_slot   = SLOT_W_CAST(fidx_q);
					res_tmr    = lru_sc_pkg::TMR_RESTART;
					res_show   = 1'b1;
				end else begin
					res_slot = SLOT_W_CAST(victim_q);
					res_tmr  = lru_sc_pkg::TMR_START;
				end
			end
			lru_sc_pkg::OP_LOOK_KEY, lru_sc_pkg::OP_LOOK_DSC,
			lru_sc_pkg::OP_CHK_DSC: begin
				if (found_q) begin
					res_status = 1'b1;
					res_slot   = SLOT_W_CAST(fidx_q);
					res_show   = 1'b1;
				end
			end
			lru_sc_pkg::OP_DEL_KEY: begin
				if (found_q) begin
					res_status = 1'b1;
					res_slot   = SLOT_W_CAST(fidx_q);
				end
			end
			lru_sc_pkg::OP_EXPIRE: begin
				if (exp_ok) begin
					res_status = 1'b1;
					res_slot   = exp_q;
				end
			end
			default: begin
				res_status = 1'b0;
			end
		endcase
	end

	// control, sweep bookkeeping and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			rd_cnt_q     <= '0;
			p_valid_s1   <= 1'b0;
			p_idx_s1     <= '0;
			v_s1         <= 1'b0;
			found_q      <= 1'b0;
			fidx_q       <= '0;
			least_q      <= '0;
			victim_q     <= '0;
			out_valid    <= 1'b0;
			status       <= 1'b0;
			slot         <= '0;
			timer_action <= lru_sc_pkg::TMR_NONE;
			found_key    <= '0;
			found_descriptor <= '0;
			found_auth   <= '0;
			found_version <= '0;
			found_hash   <= '0;
			found_sign   <= '0;
			cap_q        <= '0;
		end else begin
			if (out_valid && !out_stall && !fin_go) begin
				out_valid <= 1'b0;
			end
			p_valid_s1 <= rd_en;
			p_idx_s1   <= rd_addr;
			if (rd_en) begin
				v_s1     <= valid_q[rd_addr];
				rd_cnt_q <= rd_cnt_q + (IB+1)'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						least_q  <= lru_sc_pkg::COUNT_MAX;
						victim_q <= IB'(lru_sc_pkg::ENTRIES - 1);
						state_q  <= (opcode == lru_sc_pkg::OP_EXPIRE) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (p_valid_s1) begin
						if (op_q == lru_sc_pkg::OP_ADD) begin
							// last live key match wins, victim is strict minimum
							if (live && key_hit) begin
								found_q <= 1'b1;
								fidx_q  <= p_idx_s1;
								cap_q   <= data_s1;
							end
							if (age_dec < least_q) begin
								least_q  <= age_dec;
								victim_q <= p_idx_s1;
							end
						end else if (live && match && !found_q) begin
							found_q <= 1'b1;
							fidx_q  <= p_idx_s1;
							cap_q   <= data_s1;
						end
						if (p_idx_s1 == IB'(lru_sc_pkg::ENTRIES - 1)) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q          <= ST_IDLE;
						out_valid        <= 1'b1;
						status           <= res_status;
						slot             <= res_slot;
						timer_action     <= res_tmr;
						found_key        <= res_show ? 64'(cap_q.key) : '0;
						found_descriptor <= res_show ? cap_q.desc : '0;
						found_auth       <= res_show ? cap_q.auth : '0;
						found_version    <= res_show ? cap_q.ver : '0;
						found_hash       <= res_show ? cap_q.hash : '0;
						found_sign       <= res_show ? cap_q.sign : '0;
						// slot liveness update
						case (op_q)
							lru_sc_pkg::OP_ADD: begin
								if (!found_q) begin
									valid_q[victim_q] <= 1'b1;
								end
							end
							lru_sc_pkg::OP_DEL_KEY: begin
								if (found_q) begin
									valid_q[fidx_q] <= 1'b0;
								end
							end
							lru_sc_pkg::OP_EXPIRE: begin
								if (exp_ok) begin
									valid_q[IB'(exp_q)] <= 1'b0;
								end
							end
							default: begin
								valid_q <= valid_q;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// a new result only ever comes out of the finish step
	a_res_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FIN)
		else $error("result without finish step");

	// a miss never carries stored fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status) |-> (found_key == '0 && found_descriptor == '0 &&
		found_auth == '0))
		else $error("miss with nonzero fields");

	// an accepted word blocks the input until its finish
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not blocked after accept");

	// timer code is never the unused value
	a_timer_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> timer_action != 2'd3)
		else $error("bad timer code");
endmodule
`default_nettype wire

[verif/lru_session_cache_tb.sv]
`timescale 1ns / 1ps
module lru_session_cache_tb;

	localparam int CYCLE_LIMIT = 400000;

	// result word as seen on the output channel
	typedef struct packed {
		logic        status;
		logic [3:0]  slot;
		logic [1:0]  timer_action;
		logic [63:0] key;
		logic [31:0] desc;
		logic [31:0] auth;
		logic [15:0] ver;
		logic [7:0]  hash;
		logic [7:0]  sign;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] opcode = '0;
	logic [63:0] session_key = '0;
	logic [31:0] descriptor = '0;
	logic [31:0] auth_ident = '0;
	logic [15:0] proto_version = '0;
	logic [7:0] hash_alg = '0;
	logic [7:0] sign_alg = '0;
	logic [3:0] expire_slot = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status;
	logic [3:0] slot;
	logic [1:0] timer_action;
	logic [63:0] found_key;
	logic [31:0] found_descriptor;
	logic [31:0] found_auth;
	logic [15:0] found_version;
	logic [7:0] found_hash;
	logic [7:0] found_sign;

	lru_session_cache dut (.*);

	// shadow of the session table
	logic [lru_sc_pkg::COUNT_BITS-1:0] sh_age [lru_sc_pkg::ENTRIES];
	lru_sc_pkg::slot_data_t sh_data [lru_sc_pkg::ENTRIES];

	result_t pending_results [$];
	int errors = 0;
	int cycles = 0;
	bit idle_on = 1'b1;
	logic [63:0] key_pool [8];
	logic [31:0] desc_pool [8];

	initial forever #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic result_t show_slot(logic hit, int s, logic [1:0] tmr, bit fields);
		result_t r;
		r = '0;
		r.status = hit;
		r.slot = s[3:0];
		r.timer_action = tmr;
		if (fields) begin
			r.key = sh_data[s].key;
			r.desc = sh_data[s].desc;
			r.auth = sh_data[s].auth;
			r.ver = sh_data[s].ver;
			r.hash = sh_data[s].hash;
			r.sign = sh_data[s].sign;
		end
		return r;
	endfunction

	// session table predictor: updates shadow, returns the expected word
	function automatic result_t predict_session(logic [2:0] op, lru_sc_pkg::slot_data_t w,
			logic [3:0] xs);
		result_t r;
		int found, victim;
		logic [lru_sc_pkg::COUNT_BITS-1:0] least;
		r = '0;
		found = -1;
		if (op == lru_sc_pkg::OP_ADD) begin
			victim = lru_sc_pkg::ENTRIES - 1;
			least = lru_sc_pkg::COUNT_MAX;
			for (int i = 0; i < lru_sc_pkg::ENTRIES; i++) begin
				if (sh_age[i] != 0) begin
					sh_age[i] = sh_age[i] - 1'b1;
					if (sh_data[i].key == w.key) found = i;
				end
				if (sh_age[i] < least) begin
					least = sh_age[i];
					victim = i;
				end
			end
			if (found >= 0) begin
				sh_age[found] = lru_sc_pkg::COUNT_MAX;
				r = show_slot(1'b1, found, lru_sc_pkg::TMR_RESTART, 1'b1);
			end else begin
				sh_data[victim] = w;
				sh_age[victim] = lru_sc_pkg::COUNT_MAX;
				r = show_slot(1'b0, victim, lru_sc_pkg::TMR_START, 1'b0);
			end
		end else if (op inside {lru_sc_pkg::OP_LOOK_KEY, lru_sc_pkg::OP_LOOK_DSC,
				lru_sc_pkg::OP_CHK_DSC, lru_sc_pkg::OP_DEL_KEY}) begin
			for (int i = 0; i < lru_sc_pkg::ENTRIES; i++) begin
				if (found < 0 && sh_age[i] != 0) begin
					if ((op == lru_sc_pkg::OP_LOOK_KEY || op == lru_sc_pkg::OP_DEL_KEY) ?
							sh_data[i].key == w.key : sh_data[i].desc == w.desc)
						found = i;
				end
			end
			if (found >= 0) begin
				if (op == lru_sc_pkg::OP_DEL_KEY) begin
					sh_age[found] = '0;
					sh_data[found] = '0;
					r = show_slot(1'b1, found, lru_sc_pkg::TMR_NONE, 1'b0);
				end else begin
					if (op != lru_sc_pkg::OP_CHK_DSC) sh_age[found] = lru_sc_pkg::COUNT_MAX;
					r = show_slot(1'b1, found, lru_sc_pkg::TMR_NONE, 1'b1);
				end
			end
		end else if (op == lru_sc_pkg::OP_EXPIRE) begin
			if (xs < lru_sc_pkg::ENTRIES) begin
				sh_age[xs] = '0;
				sh_data[xs] = '0;
				r = show_slot(1'b1, xs, lru_sc_pkg::TMR_NONE, 1'b0);
			end
		end
		return r;
	endfunction

	// send one operation word, holding it until accepted
	task automatic send_op(logic [2:0] op, logic [63:0] k, logic [31:0] d,
			logic [31:0] a, logic [15:0] v, logic [7:0] h, logic [7:0] s,
			logic [3:0] xs);
		lru_sc_pkg::slot_data_t w;
		do @(negedge clk); while (idle_on && $urandom_range(99) < 21);
		opcode <= op;
		session_key <= k;
		descriptor <= d;
		auth_ident <= a;
		proto_version <= v;
		hash_alg <= h;
		sign_alg <= s;
		expire_slot <= xs;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		w = '{key: k, desc: d, auth: a, ver: v, hash: h, sign: s};
		pending_results.push_back(predict_session(op, w, xs));
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_rand(logic [2:0] op);
		send_op(op, key_pool[3'($urandom_range(7))], desc_pool[3'($urandom_range(7))],
			$urandom, 16'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (lru_sc_pkg::ENTRIES + 4) @(negedge clk);
	endtask

	// receiver stall
	always @(negedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 21);
	end

	// result checker
	always @(posedge clk) begin
		result_t got, exp_r;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, slot, timer_action, found_key, found_descriptor,
				found_auth, found_version, found_hash, found_sign};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (got.status !== exp_r.status)
					$display("%0t: status exp %h got %h", $realtime, exp_r.status, got.status);
				if (got.slot !== exp_r.slot)
					$display("%0t: slot exp %h got %h", $realtime, exp_r.slot, got.slot);
				if (got.timer_action !== exp_r.timer_action)
					$display("%0t: timer exp %h got %h", $realtime,
						exp_r.timer_action, got.timer_action);
				if (got.key !== exp_r.key)
					$display("%0t: key exp %h got %h", $realtime, exp_r.key, got.key);
				if (got.desc !== exp_r.desc)
					$display("%0t: desc exp %h got %h", $realtime, exp_r.desc, got.desc);
				if (got.auth !== exp_r.auth)
					$display("%0t: auth exp %h got %h", $realtime, exp_r.auth, got.auth);
				if (got.ver !== exp_r.ver)
					$display("%0t: version exp %h got %h", $realtime, exp_r.ver, got.ver);
				if (got.hash !== exp_r.hash)
					$display("%0t: hash exp %h got %h", $realtime, exp_r.hash, got.hash);
				if (got.sign !== exp_r.sign)
					$display("%0t: sign exp %h got %h", $realtime, exp_r.sign, got.sign);
				if (got !== exp_r) errors++;
			end
		end
	end

	// extremes, every opcode, unused codes, eviction and last-slot default
	task automatic test_directed();
		send_op(lru_sc_pkg::OP_LOOK_KEY, '0, '0, '0, '0, '0, '0, '0);
		send_op(lru_sc_pkg::OP_ADD, '1, '1, '1, '1, '1, '1, '1);
		send_op(lru_sc_pkg::OP_ADD, '0, '0, '0, '0, '0, '0, '0);
		send_op(lru_sc_pkg::OP_ADD, '1, 32'h5, 32'h6, 16'h7, 8'h8, 8'h9, '0);
		send_op(lru_sc_pkg::OP_LOOK_KEY, '1, '0, '0, '0, '0, '0, '0);
		send_op(lru_sc_pkg::OP_LOOK_DSC, '0, '1, '0, '0, '0, '0, '0);
		send_op(lru_sc_pkg::OP_CHK_DSC, '0, '0, '0, '0, '0, '0, '0);
		send_op(lru_sc_pkg::OP_CHK_DSC, '0, 32'h1234, '0, '0, '0, '0, '0);
		send_op(lru_sc_pkg::OP_DEL_KEY, '0, '0, '0, '0, '0, '0, '0);
		send_op(lru_sc_pkg::OP_DEL_KEY, '0, '0, '0, '0, '0, '0, '0);
		send_op(lru_sc_pkg::OP_EXPIRE, '0, '0, '0, '0, '0, '0, 4'd15);
		send_op(lru_sc_pkg::OP_EXPIRE, '0, '0, '0, '0, '0, '0, 4'd0);
		send_op(3'd6, '1, '1, '1, '1, '1, '1, '1);
		send_op(3'd7, '1, '1, '1, '1, '1, '1, '1);
		// fill all slots, then two more force evictions
		for (int i = 0; i < lru_sc_pkg::ENTRIES + 2; i++)
			send_op(lru_sc_pkg::OP_ADD, 64'h100 + i, i, $urandom, 16'($urandom),
				8'($urandom), 8'($urandom), '0);
	endtask

	// mostly adds and lookups over a small key pool to get hits
	task automatic test_random(int n);
		int p;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				key_pool[3'($urandom_range(7))] = {$urandom, $urandom};
				desc_pool[3'($urandom_range(7))] = $urandom;
			end
			idle_on = !(i >= 300 && i < 400);
			p = $urandom_range(99);
			if (p < 40) send_rand(lru_sc_pkg::OP_ADD);
			else if (p < 55) send_rand(lru_sc_pkg::OP_LOOK_KEY);
			else if (p < 67) send_rand(lru_sc_pkg::OP_LOOK_DSC);
			else if (p < 77) send_rand(lru_sc_pkg::OP_CHK_DSC);
			else if (p < 87) send_rand(lru_sc_pkg::OP_DEL_KEY);
			else if (p < 95) send_rand(lru_sc_pkg::OP_EXPIRE);
			else send_op(3'($urandom_range(7)), {$urandom, $urandom}, $urandom, $urandom,
				16'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
		end
		idle_on = 1'b1;
	endtask

	// sender waits for the pipe to empty mid-stream
	task automatic test_pause();
		send_rand(lru_sc_pkg::OP_ADD);
		drain_results();
		send_rand(lru_sc_pkg::OP_LOOK_KEY);
	endtask

	initial begin
		for (int i = 0; i < lru_sc_pkg::ENTRIES; i++) begin
			sh_age[i] = '0;
			sh_data[i] = '0;
		end
		for (int i = 0; i < 8; i++) begin
			key_pool[i] = {$urandom, $urandom};
			desc_pool[i] = $urandom;
		end
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_pause();
		test_random(820);
		drain_results();
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

[files.f]
rtl/core/lru_sc_pkg.sv
rtl/core/lru_session_cache.sv
verif/lru_session_cache_tb.sv
